// ----- sv/encoder_to_servo_angle_stepper_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the encoder servo angle stepper.
// Each macro expands to one labeled concurrent assertion on clk, held off
// while rst is high.
// ----------------------------------------------------------------------------
`ifndef ENCODER_TO_SERVO_ANGLE_STEPPER_ASSERT_SVH
`define ENCODER_TO_SERVO_ANGLE_STEPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESAS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/esas_pkg.sv -----
// ----------------------------------------------------------------------------
// esas_pkg
// Shared types and constants for the encoder servo angle stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package esas_pkg;

  // Input word: command code and running encoder total.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] enc_count;
  } in_word_t;

  // Output word: angle after the item and two flags.
  typedef struct packed {
    logic [7:0] servo_angle;
    logic       stepped;
    logic       baseline_taken;
  } out_word_t;

  // Command codes.
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_REBASE = 2'd1;
  localparam logic [1:0] ACT_INIT   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MIN_ANGLE       = 3'd0;
  localparam logic [2:0] CFG_MAX_ANGLE       = 3'd1;
  localparam logic [2:0] CFG_CENTER_ANGLE    = 3'd2;
  localparam logic [2:0] CFG_ANGLE_STEP      = 3'd3;
  localparam logic [2:0] CFG_COUNTS_PER_STEP = 3'd4;

  // Configuration reset values.
  localparam logic [7:0] RST_MIN_ANGLE       = 8'd30;
  localparam logic [7:0] RST_MAX_ANGLE       = 8'd150;
  localparam logic [7:0] RST_CENTER_ANGLE    = 8'd90;
  localparam logic [7:0] RST_ANGLE_STEP      = 8'd5;
  localparam logic [7:0] RST_COUNTS_PER_STEP = 8'd5;

  // Width of the divided magnitude; one quotient bit per divider step.
  localparam int DIV_BITS = 16;
  localparam int CNT_W    = $clog2(DIV_BITS);

  typedef struct packed {
    logic [7:0] min_angle;
    logic [7:0] max_angle;
    logic [7:0] center_angle;
    logic [7:0] angle_step;
    logic [7:0] counts_per_step;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;     // capture the accepted input word
    logic prep;      // form the delta and sum, or apply a non-update command
    logic div_step;  // one restoring division step
    logic scale;     // quotient times angle step
    logic apply;     // new angle, clamp, remainder write-back
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;  // update with a valid baseline
    logic out_free;  // output register can take a word this cycle
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SCALE,
    ST_APPLY,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/esas_ctrl.sv -----
// ----------------------------------------------------------------------------
// esas_ctrl
// Sequencer for one item: prepare, divide bit by bit, scale, apply, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "encoder_to_servo_angle_stepper_assert.svh"

module esas_ctrl
  import esas_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = st.need_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_BITS - 1)) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ESAS_ASSERT_NEXT(a_accept_prep, in_valid && !in_stall, state == ST_PREP,
                    "accepted word did not enter preparation")
  `ESAS_ASSERT_NEXT(a_div_length, state == ST_DIV && cnt == CNT_W'(DIV_BITS - 1),
                    state == ST_SCALE, "division did not end after its last step")
  `ESAS_ASSERT_SAME(a_load_free, cmd.load_out, st.out_free,
                    "output loaded while the previous word was still held")
  `ESAS_ASSERT_NEXT(a_short_path, state == ST_PREP && !st.need_div,
                    state == ST_DONE, "command without division did not finish")

endmodule

`default_nettype wire

// ----- sv/esas_datapath.sv -----
// ----------------------------------------------------------------------------
// esas_datapath
// Angle state, remainder, restoring divider, scaler, clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esas_datapath
  import esas_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire in_word_t in_data,
  input  wire cmd_t     cmd,
  output status_t       st,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_data
);

  in_word_t             item;
  logic [15:0]          last_low;     // only the low half feeds the wrapped delta
  logic                 base_valid;
  logic signed [8:0]    remainder;    // magnitude stays below the divisor
  logic [7:0]           angle;
  logic                 neg;
  logic [7:0]           divisor;
  logic [DIV_BITS-1:0]  dvd;
  logic [7:0]           part_rem;
  logic [23:0]          prod;
  logic                 q_nonzero;
  logic                 changed;
  logic                 baseline;

  logic [15:0]          d16;
  logic signed [16:0]   sum;
  logic [16:0]          sum_mag;
  logic [8:0]           trial;
  logic                 fits;
  logic signed [25:0]   new_angle;
  logic [7:0]           clamped;

  assign st.need_div = (item.action == ACT_UPDATE) && base_valid;
  assign st.out_free = !out_valid || !out_stall;

  always_comb begin
    d16     = item.enc_count[15:0] - last_low;
    sum     = {{8{remainder[8]}}, remainder} + {d16[15], d16};
    sum_mag = sum[16] ? 17'(-sum) : 17'(sum);
    trial   = {part_rem, dvd[DIV_BITS-1]};
    fits    = trial >= {1'b0, divisor};
    if (neg) begin
      new_angle = $signed({18'd0, angle}) - $signed({2'd0, prod});
    end else begin
      new_angle = $signed({18'd0, angle}) + $signed({2'd0, prod});
    end
    if (new_angle < $signed({18'd0, cfg.min_angle})) begin
      clamped = cfg.min_angle;
    end else if (new_angle > $signed({18'd0, cfg.max_angle})) begin
      clamped = cfg.max_angle;
    end else begin
      clamped = new_angle[7:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
    if (cmd.prep) begin
      neg      <= sum[16];
      dvd      <= sum_mag[DIV_BITS-1:0];
      part_rem <= '0;
      divisor  <= (cfg.counts_per_step == 8'd0) ? 8'd1 : cfg.counts_per_step;
      changed  <= 1'b0;
      baseline <= (item.action == ACT_UPDATE) && !base_valid;
    end
    if (cmd.div_step) begin
      part_rem <= fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      dvd      <= {dvd[DIV_BITS-2:0], fits};
    end
    if (cmd.scale) begin
      prod      <= 24'(dvd) * 24'(cfg.angle_step);
      q_nonzero <= dvd != '0;
    end
    if (cmd.apply) begin
      changed <= q_nonzero;
    end
    if (cmd.load_out) begin
      out_data.servo_angle    <= angle;
      out_data.stepped        <= changed;
      out_data.baseline_taken <= baseline;
    end
  end

  // Architectural state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_low   <= '0;
      base_valid <= 1'b0;
      remainder  <= '0;
      angle      <= RST_CENTER_ANGLE;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.prep) begin
        case (item.action)
          ACT_UPDATE: begin
            last_low   <= item.enc_count[15:0];
            base_valid <= 1'b1;
          end
          ACT_REBASE: begin
            remainder  <= '0;
            base_valid <= 1'b0;
          end
          ACT_INIT: begin
            remainder  <= '0;
            last_low   <= '0;
            base_valid <= 1'b0;
            angle      <= cfg.center_angle;
          end
          default: begin
          end
        endcase
      end
      if (cmd.apply) begin
        remainder <= neg ? -$signed({1'b0, part_rem}) : $signed({1'b0, part_rem});
        if (q_nonzero) begin
          angle <= clamped;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/encoder_to_servo_angle_stepper.sv -----
// Flow: an update word with a recorded baseline goes through preparation, the 16-step
// serial divider, scaling and apply; a baseline-only update, rebaseline, init or unused
// code goes from preparation straight to delivery. A new word is taken only after the
// last result reaches the output register; a stalled output holds the next result back.
// Reset (rst, synchronous, active high) restores register defaults, angle 90, no baseline.
// ----------------------------------------------------------------------------
// encoder_to_servo_angle_stepper
// Turns a running encoder total into stepped, clamped servo target angles.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_to_servo_angle_stepper
  import esas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_data,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_data,
  // Configuration write channel.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  // The configuration registers are always writable. The host must write them only while
  // no word is in flight; the block does not enforce it. The datapath reads them directly.
  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_angle       <= RST_MIN_ANGLE;
      cfg.max_angle       <= RST_MAX_ANGLE;
      cfg.center_angle    <= RST_CENTER_ANGLE;
      cfg.angle_step      <= RST_ANGLE_STEP;
      cfg.counts_per_step <= RST_COUNTS_PER_STEP;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes past the last register are accepted and dropped.
      case (cfg_index)
        CFG_MIN_ANGLE:       cfg.min_angle       <= cfg_data;
        CFG_MAX_ANGLE:       cfg.max_angle       <= cfg_data;
        CFG_CENTER_ANGLE:    cfg.center_angle    <= cfg_data;
        CFG_ANGLE_STEP:      cfg.angle_step      <= cfg_data;
        CFG_COUNTS_PER_STEP: cfg.counts_per_step <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The controller accepts a word only when idle and walks it through the
  // preparation, division, scaling and apply steps. Commands other than a
  // full update skip straight from preparation to delivery.
  esas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the angle, remainder and baseline state. The wrapped
  // delta is added to the remainder, and the sum's magnitude is divided by
  // counts_per_step one quotient bit per cycle. The quotient times angle_step
  // then moves the angle, which is clamped only when at least one step was
  // taken. The output register lets the next word enter while a result waits.
  esas_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/encoder_to_servo_angle_stepper_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_to_servo_angle_stepper_tb
// Self-checking bench for the encoder servo angle stepper. A short directed
// run covers the wrap of the 16-bit count difference, signed remainders, the
// three commands and the unused code, a zero group size, a zero step and a
// minimum above the maximum. Random phases with changing register settings
// and changing idle and stall patterns follow. Every accepted input word is
// run through a behavioral copy of the stepper, and every result word is
// compared, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module encoder_to_servo_angle_stepper_tb;
  import esas_pkg::*;

  // The package names three commands; the fourth code is ignored by the block.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Generous bound for roughly 1550 words in the worst idle and stall mix.
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 30;
  localparam int WORDS_PER_PHASE = 190;
  localparam int RANDOM_PHASES = 8;

  // --------------------------------------------------------------------------
  // Behavioral copy of the stepper plus the queue of result words still due.
  // --------------------------------------------------------------------------
  class angle_tracker;
    cfg_t        cfg;
    logic [31:0] prev_total;
    bit          has_baseline;
    int          leftover;
    logic [7:0]  angle;
    out_word_t   angle_words_due[$];
    int          mismatches;
    int          words_checked;
    int          moves_seen;
    int          baselines_seen;

    function new();
      cfg.min_angle       = RST_MIN_ANGLE;
      cfg.max_angle       = RST_MAX_ANGLE;
      cfg.center_angle    = RST_CENTER_ANGLE;
      cfg.angle_step      = RST_ANGLE_STEP;
      cfg.counts_per_step = RST_COUNTS_PER_STEP;
      prev_total     = '0;
      has_baseline   = 1'b0;
      leftover       = 0;
      angle          = RST_CENTER_ANGLE;
      mismatches     = 0;
      words_checked  = 0;
      moves_seen     = 0;
      baselines_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] value);
      case (idx)
        CFG_MIN_ANGLE:       cfg.min_angle = value;
        CFG_MAX_ANGLE:       cfg.max_angle = value;
        CFG_CENTER_ANGLE:    cfg.center_angle = value;
        CFG_ANGLE_STEP:      cfg.angle_step = value;
        CFG_COUNTS_PER_STEP: cfg.counts_per_step = value;
        default: ;
      endcase
    endfunction

    // Advances the copy by one accepted word and queues the word it must give.
    function void take_command(in_word_t w);
      out_word_t   res;
      logic [15:0] diff16;
      int          delta;
      int          sum;
      int          group;
      int          steps;
      longint      raw_angle;
      res.stepped        = 1'b0;
      res.baseline_taken = 1'b0;
      case (w.action)
        ACT_UPDATE: begin
          if (!has_baseline) begin
            prev_total         = w.enc_count;
            has_baseline       = 1'b1;
            res.baseline_taken = 1'b1;
          end else begin
            diff16 = w.enc_count[15:0] - prev_total[15:0];
            delta  = $signed(diff16);
            sum    = leftover + delta;
            group  = (cfg.counts_per_step == 8'd0) ? 1 : int'(cfg.counts_per_step);
            // Both sides truncate toward zero, so the leftover keeps the sign.
            steps      = sum / group;
            leftover   = sum - steps * group;
            prev_total = w.enc_count;
            if (steps != 0) begin
              raw_angle = longint'(angle) + longint'(steps) * longint'(cfg.angle_step);
              if (raw_angle < longint'(cfg.min_angle))
                angle = cfg.min_angle;
              else if (raw_angle > longint'(cfg.max_angle))
                angle = cfg.max_angle;
              else
                angle = raw_angle[7:0];
              res.stepped = 1'b1;
            end
          end
        end
        ACT_REBASE: begin
          leftover     = 0;
          has_baseline = 1'b0;
        end
        ACT_INIT: begin
          leftover     = 0;
          prev_total   = '0;
          has_baseline = 1'b0;
          angle        = cfg.center_angle;
        end
        default: ;
      endcase
      res.servo_angle = angle;
      if (res.stepped) moves_seen++;
      if (res.baseline_taken) baselines_seen++;
      angle_words_due.push_back(res);
    endfunction

    function void match_angle_word(out_word_t got);
      out_word_t want;
      if (angle_words_due.size() == 0) begin
        $error("result word %h arrived with no prediction outstanding", got);
        mismatches++;
        return;
      end
      want = angle_words_due.pop_front();
      words_checked++;
      if (got.servo_angle !== want.servo_angle) begin
        $error("servo_angle: expected %0d, got %0d", want.servo_angle, got.servo_angle);
        mismatches++;
      end
      if (got.stepped !== want.stepped) begin
        $error("stepped: expected %0b, got %0b", want.stepped, got.stepped);
        mismatches++;
      end
      if (got.baseline_taken !== want.baseline_taken) begin
        $error("baseline_taken: expected %0b, got %0b", want.baseline_taken,
               got.baseline_taken);
        mismatches++;
      end
    endfunction

    function int words_pending();
      return angle_words_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its channels.
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  encoder_to_servo_angle_stepper dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  angle_tracker tracker;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls; the main sequence changes them from phase to phase.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;
  int          words_sent = 0;
  // Running encoder position that the random updates walk from.
  logic [31:0] enc_pos = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random receiver stalls. One assignment per edge, so a stall level is
  // never overwritten within a time step.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result monitor. Sampling right after the edge sees the values that held
  // at the edge, since everything here and in the block updates through
  // nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.match_angle_word(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words still due", cycle_count,
               tracker.words_pending());
      $display("encoder_to_servo_angle_stepper verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offers one word and returns at the edge where it is taken. Idle cycles
  // go in front of the word, so valid is lowered only at the edge where the
  // previous word was taken or during a gap, never while a word waits.
  task automatic send_word(input logic [1:0] action, input logic [31:0] total);
    in_word_t w;
    w.action    = action;
    w.enc_count = total;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    tracker.take_command(w);
    words_sent++;
  endtask

  // Stops sending and waits for every outstanding result word. Every word
  // gives exactly one result, so an empty queue means the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.words_pending() != 0);
  endtask

  // One register write; valid stays up across back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    tracker.set_reg(idx, value);
  endtask

  task automatic write_all_regs(input logic [7:0] lo, input logic [7:0] hi,
                                input logic [7:0] center, input logic [7:0] step,
                                input logic [7:0] group);
    write_reg(CFG_MIN_ANGLE, lo);
    write_reg(CFG_MAX_ANGLE, hi);
    write_reg(CFG_CENTER_ANGLE, center);
    write_reg(CFG_ANGLE_STEP, step);
    write_reg(CFG_COUNTS_PER_STEP, group);
    cfg_valid <= 1'b0;
  endtask

  // One random word. Most are updates that walk the encoder position by a
  // few groups, so the stepping and clamping paths see real traffic; the
  // rest are large jumps, fully random totals, commands and the unused code.
  task automatic send_random_word(input int group);
    int r;
    int span;
    int delta;
    logic [31:0] noise;
    r     = $urandom_range(0, 99);
    noise = $urandom();
    if (r < 7) begin
      send_word(ACT_REBASE, noise);
    end else if (r < 13) begin
      send_word(ACT_INIT, noise);
    end else if (r < 17) begin
      send_word(ACT_UNUSED, noise);
    end else if (r < 26) begin
      enc_pos = noise;
      send_word(ACT_UPDATE, enc_pos);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70)
        span = 3 * group + 2;
      else if (r < 90)
        span = 1000;
      else
        span = 40000;
      delta   = int'($urandom_range(0, 2 * span)) - span;
      enc_pos = enc_pos + delta;
      send_word(ACT_UPDATE, enc_pos);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] center;
    logic [7:0] step;
    logic [7:0] group;
    logic [7:0] swap;
    int         mode;

    tracker = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MIN_ANGLE;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings: range 30 to 150, center 90, 5 degrees
    // per group of 5 counts.
    // The first update only takes the baseline, at the top of the total range.
    send_word(ACT_UPDATE, 32'h7FFF_FFFF);
    // Crossing the 32-bit wrap is a difference of one.
    send_word(ACT_UPDATE, 32'h8000_0000);
    // The remainder reaches a whole group: one step up.
    send_word(ACT_UPDATE, 32'h8000_0004);
    // Largest positive 16-bit difference: thousands of steps, clamped high.
    send_word(ACT_UPDATE, 32'h8000_8003);
    // Largest negative difference: clamped low, remainder left negative.
    send_word(ACT_UPDATE, 32'h8000_0003);
    // Small negative move with no whole group: the angle is kept.
    send_word(ACT_UPDATE, 32'h8000_0001);
    // A positive move cancels the negative remainder; the next one completes a group.
    send_word(ACT_UPDATE, 32'h8000_0008);
    send_word(ACT_UPDATE, 32'h8000_0009);
    // The unused code changes nothing.
    send_word(ACT_UNUSED, 32'hFFFF_FFFF);
    // Rebaseline, then a new baseline and moves downward.
    send_word(ACT_REBASE, 32'h0000_0000);
    send_word(ACT_UPDATE, 32'h0000_1234);
    send_word(ACT_UPDATE, 32'h0000_1230);
    send_word(ACT_UPDATE, 32'h0000_122F);
    // Init returns to center; the totals on either side of zero follow.
    send_word(ACT_INIT, 32'h5555_5555);
    send_word(ACT_UPDATE, 32'hFFFF_FFFF);
    send_word(ACT_UPDATE, 32'h0000_0000);
    drain_results();

    // Minimum above maximum, center 0 loaded without clamping, a zero step
    // and a zero group size (taken as one).
    write_all_regs(8'd120, 8'd60, 8'd0, 8'd0, 8'd0);
    send_word(ACT_INIT, 32'h0000_0000);
    send_word(ACT_UPDATE, 32'd100);
    // A zero step still counts as a move: 0 falls below the minimum.
    send_word(ACT_UPDATE, 32'd101);
    // 120 is not below the minimum but is above the maximum.
    send_word(ACT_UPDATE, 32'd99);
    send_word(ACT_UPDATE, 32'd99);
    drain_results();

    // Random phases. The first three use fixed settings at the edges of the
    // register ranges and the reset values; the rest draw settings at
    // random, now and then with the limits swapped or a zero step or group.
    // The idle pattern cycles through none, sender only, receiver only and
    // both.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          lo = 8'd0; hi = 8'd180; center = 8'd180; step = 8'd180; group = 8'd255;
        end
        1: begin
          lo = 8'd0; hi = 8'd180; center = 8'd0; step = 8'd1; group = 8'd1;
        end
        2: begin
          lo = RST_MIN_ANGLE; hi = RST_MAX_ANGLE; center = RST_CENTER_ANGLE;
          step = RST_ANGLE_STEP; group = RST_COUNTS_PER_STEP;
        end
        default: begin
          lo     = 8'($urandom_range(0, 90));
          hi     = 8'($urandom_range(90, 180));
          center = 8'($urandom_range(0, 180));
          step   = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 30));
          group  = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 40));
          if ($urandom_range(0, 4) == 0) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
          end
        end
      endcase
      write_all_regs(lo, hi, center, step, group);

      mode = phase % 4;
      send_idle_pct  = (mode == 1) ? 45 : (mode == 3) ? 22 : 0;
      recv_stall_pct = (mode == 2) ? 45 : (mode == 3) ? 22 : 0;
      for (int i = 0; i < WORDS_PER_PHASE; i++)
        send_random_word((group == 8'd0) ? 1 : int'(group));
      drain_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end

    // Let any stray word show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input words across %0d random phases after the directed part.",
             words_sent, RANDOM_PHASES);
    $display("Checked %0d result words: %0d angle moves, %0d baseline captures.",
             tracker.words_checked, tracker.moves_seen, tracker.baselines_seen);
    if (tracker.mismatches == 0 && tracker.words_pending() == 0)
      $display("encoder_to_servo_angle_stepper verification clean");
    else
      $display("encoder_to_servo_angle_stepper verification failed");
    $finish;
  end

endmodule

// ----- encoder_to_servo_angle_stepper.f -----
+incdir+sv
sv/esas_pkg.sv
sv/esas_ctrl.sv
sv/esas_datapath.sv
sv/encoder_to_servo_angle_stepper.sv
tb/encoder_to_servo_angle_stepper_tb.sv
